>>> rtl/amls_pkg.sv
// Shared types, codes and constants of the AT modem link sequencer.
package amls_pkg;

    localparam int LINE_MAX_DEF = 32;
    localparam int ADDR_MAX_DEF = 16;
    localparam int RESULT_LIMIT = 16;
    localparam int Q_DEPTH      = 4;

    localparam logic [1:0] OP_BYTE = 2'd0;
    localparam logic [1:0] OP_TICK = 2'd1;
    localparam logic [1:0] OP_SEND = 2'd2;

    localparam logic [1:0] CMD_PROBE = 2'd0;
    localparam logic [1:0] CMD_DNS   = 2'd1;
    localparam logic [1:0] CMD_OPEN  = 2'd2;
    localparam logic [1:0] CMD_SEND  = 2'd3;

    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_DOT = 8'h2E;

    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_EOL  = 2'd1,
        KIND_TICK = 2'd2,
        KIND_SEND = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
    } entry_t;

    typedef struct packed {
        logic   push;
        entry_t entry;
    } q_wr_t;

    typedef struct packed {
        logic   empty;
        entry_t entry;
    } q_rd_t;

    typedef enum logic [2:0] {
        LINK_INIT = 3'b001,
        LINK_DISC = 3'b010,
        LINK_CONN = 3'b100
    } link_t;

    typedef enum logic [1:0] {
        EX_RUN    = 2'b01,
        EX_STREAM = 2'b10
    } exec_t;

endpackage

>>> rtl/amls_in_if.sv
// Input channel carrying operation items from the host side.
interface amls_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] rx_byte;

    modport source (output valid, output operation, output rx_byte, input ready);
    modport sink (input valid, input operation, input rx_byte, output ready);
endinterface

>>> rtl/amls_out_if.sv
// Output channel carrying command results.
interface amls_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] addr_char;
    logic       last;

    modport source (output valid, output command, output addr_char, output last, input ready);
    modport sink (input valid, input command, input addr_char, input last, output ready);
endinterface

>>> rtl/amls_front.sv
// Front end: accepts input transfers and classifies them into queue entries.
module amls_front (
    amls_in_if.sink          item,
    input  logic             full,
    output amls_pkg::q_wr_t  wr
);

    logic               fire;
    logic               drop;
    amls_pkg::kind_t    kind;

    assign item.ready = !full;
    assign fire       = item.valid && item.ready;

    always_comb
    begin
        drop = 1'b0;
        kind = amls_pkg::KIND_CHAR;
        case (item.operation)
            amls_pkg::OP_BYTE:
            begin
                if (item.rx_byte == amls_pkg::CHAR_CR)
                begin
                    kind = amls_pkg::KIND_EOL;
                end
                else if (item.rx_byte inside {amls_pkg::CHAR_NUL, amls_pkg::CHAR_LF})
                begin
                    drop = 1'b1;
                end
            end
            amls_pkg::OP_TICK:
            begin
                kind = amls_pkg::KIND_TICK;
            end
            amls_pkg::OP_SEND:
            begin
                kind = amls_pkg::KIND_SEND;
            end
            default:
            begin
                drop = 1'b1;
            end
        endcase
    end

    assign wr.push       = fire && !drop;
    assign wr.entry.kind = kind;
    assign wr.entry.data = item.rx_byte;

endmodule

>>> rtl/amls_queue.sv
// Short queue of classified entries between the front and back ends.
module amls_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  amls_pkg::q_wr_t  wr,
    input  logic             pop,
    output logic             full,
    output amls_pkg::q_rd_t  rd
);

    localparam int QAW = $clog2(amls_pkg::Q_DEPTH);
    localparam int QCW = $clog2(amls_pkg::Q_DEPTH + 1);

    amls_pkg::entry_t   mem_reg [amls_pkg::Q_DEPTH];
    logic [QAW-1:0]     wr_ptr_reg;
    logic [QAW-1:0]     wr_ptr_next;
    logic [QAW-1:0]     rd_ptr_reg;
    logic [QAW-1:0]     rd_ptr_next;
    logic [QCW-1:0]     count_reg;
    logic [QCW-1:0]     count_next;

    assign full     = count_reg == QCW'(amls_pkg::Q_DEPTH);
    assign rd.empty = count_reg == '0;
    assign rd.entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr.push)
        begin
            wr_ptr_next = (wr_ptr_reg == QAW'(amls_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_reg + QAW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QAW'(amls_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_reg + QAW'(1);
        end
        if (wr.push && !pop)
        begin
            count_next = count_reg + QCW'(1);
        end
        else if (pop && !wr.push)
        begin
            count_next = count_reg - QCW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.push)
        begin
            mem_reg[wr_ptr_reg] <= wr.entry;
        end
    end

endmodule

>>> rtl/amls_back.sv
// Back end: line assembly, line classification, link state machine and result output.
module amls_back #(
    parameter int LINE_MAX = amls_pkg::LINE_MAX_DEF,
    parameter int ADDR_MAX = amls_pkg::ADDR_MAX_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  amls_pkg::q_rd_t  q_rd,
    output logic             pop,
    amls_out_if.source       result
);

    localparam int LLW    = $clog2(LINE_MAX + 1);
    localparam int ALW    = $clog2(ADDR_MAX + 1);
    localparam int AIW    = $clog2(ADDR_MAX);
    localparam int CW     = (LLW > ALW) ? LLW : ALW;
    localparam int HEAD_N = 10;

    localparam logic [15:0] WORD_AT      = "AT";
    localparam logic [39:0] WORD_ERROR   = "ERROR";
    localparam logic [15:0] WORD_OK      = "OK";
    localparam logic [79:0] WORD_CONNECT = "CONNECT OK";
    localparam logic [55:0] WORD_SEND_OK = "SEND OK";

    amls_pkg::link_t    link_reg;
    amls_pkg::link_t    link_next;
    amls_pkg::exec_t    ex_reg;
    amls_pkg::exec_t    ex_next;
    logic               ok_reg;
    logic               ok_next;
    logic               found_reg;
    logic               found_next;
    logic               pend_reg;
    logic               pend_next;
    logic [LLW-1:0]     line_len_reg;
    logic [LLW-1:0]     line_len_next;
    logic               ovf_reg;
    logic               ovf_next;
    logic [ALW-1:0]     addr_len_reg;
    logic [ALW-1:0]     addr_len_next;
    logic [AIW-1:0]     idx_reg;
    logic [AIW-1:0]     idx_next;
    logic [AIW-1:0]     last_idx_reg;
    logic [AIW-1:0]     last_idx_next;
    logic [7:0]         line_keep_reg [ADDR_MAX];
    logic [7:0]         addr_store_reg [ADDR_MAX];
    logic               out_valid_reg;
    logic [1:0]         out_cmd_reg;
    logic [7:0]         out_char_reg;
    logic               out_last_reg;

    logic               can_load;
    logic               out_load;
    logic [1:0]         o_cmd;
    logic [7:0]         o_char;
    logic               o_last;
    logic               keep_we;
    logic               addr_copy;
    logic [8*HEAD_N-1:0] head;
    logic               m_at;
    logic               m_error;
    logic               m_ok;
    logic               m_connect;
    logic               m_send_ok;
    logic               is_addr;
    logic [ALW-1:0]     line_clip;
    logic [AIW-1:0]     stream_last;

    assign can_load = !out_valid_reg || result.ready;

    always_comb
    begin
        for (int i = 0; i < HEAD_N; i++)
        begin
            head[8*(HEAD_N-1-i) +: 8] = line_keep_reg[i];
        end
    end

    assign m_at      = !ovf_reg && line_len_reg == LLW'(2) && head[79 -: 16] == WORD_AT;
    assign m_error   = !ovf_reg && line_len_reg == LLW'(5) && head[79 -: 40] == WORD_ERROR;
    assign m_ok      = !ovf_reg && line_len_reg == LLW'(2) && head[79 -: 16] == WORD_OK;
    assign m_connect = !ovf_reg && line_len_reg == LLW'(10) && head == WORD_CONNECT;
    assign m_send_ok = !ovf_reg && line_len_reg == LLW'(7) && head[79 -: 56] == WORD_SEND_OK;

    assign is_addr = !ovf_reg
        && ((line_len_reg > LLW'(6) && line_keep_reg[2] == amls_pkg::CHAR_DOT
             && line_keep_reg[6] == amls_pkg::CHAR_DOT)
         || (line_len_reg > LLW'(7) && line_keep_reg[3] == amls_pkg::CHAR_DOT
             && line_keep_reg[7] == amls_pkg::CHAR_DOT));

    assign line_clip = (CW'(line_len_reg) < CW'(ADDR_MAX)) ? ALW'(line_len_reg) : ALW'(ADDR_MAX);

    assign stream_last = (addr_len_reg > ALW'(amls_pkg::RESULT_LIMIT))
        ? AIW'(amls_pkg::RESULT_LIMIT - 1) : AIW'(addr_len_reg - ALW'(1));

    always_comb
    begin
        link_next     = link_reg;
        ex_next       = ex_reg;
        ok_next       = ok_reg;
        found_next    = found_reg;
        pend_next     = pend_reg;
        line_len_next = line_len_reg;
        ovf_next      = ovf_reg;
        addr_len_next = addr_len_reg;
        idx_next      = idx_reg;
        last_idx_next = last_idx_reg;
        pop           = 1'b0;
        keep_we       = 1'b0;
        addr_copy     = 1'b0;
        out_load      = 1'b0;
        o_cmd         = amls_pkg::CMD_PROBE;
        o_char        = '0;
        o_last        = 1'b1;
        case (ex_reg)
            amls_pkg::EX_RUN:
            begin
                if (!q_rd.empty && can_load)
                begin
                    pop = 1'b1;
                    case (q_rd.entry.kind)
                        amls_pkg::KIND_CHAR:
                        begin
                            if (line_len_reg != LLW'(LINE_MAX))
                            begin
                                line_len_next = line_len_reg + LLW'(1);
                                keep_we       = CW'(line_len_reg) < CW'(ADDR_MAX);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        amls_pkg::KIND_EOL:
                        begin
                            if (line_len_reg != '0)
                            begin
                                if (m_at)
                                begin
                                    ok_next = ok_reg;
                                end
                                else if (m_error)
                                begin
                                    ok_next = 1'b0;
                                end
                                else
                                begin
                                    case (link_reg)
                                        amls_pkg::LINK_DISC:
                                        begin
                                            if (m_connect)
                                            begin
                                                ok_next = 1'b1;
                                            end
                                        end
                                        amls_pkg::LINK_CONN:
                                        begin
                                            if (m_send_ok)
                                            begin
                                                ok_next = 1'b1;
                                            end
                                        end
                                        default:
                                        begin
                                            if (m_ok)
                                            begin
                                                ok_next = 1'b1;
                                            end
                                        end
                                    endcase
                                end
                                if (is_addr)
                                begin
                                    addr_copy     = 1'b1;
                                    addr_len_next = line_clip;
                                    found_next    = 1'b1;
                                end
                                line_len_next = '0;
                                ovf_next      = 1'b0;
                            end
                        end
                        amls_pkg::KIND_TICK:
                        begin
                            case (link_reg)
                                amls_pkg::LINK_DISC:
                                begin
                                    if (pend_reg)
                                    begin
                                        if (ok_reg)
                                        begin
                                            ok_next   = 1'b0;
                                            link_next = amls_pkg::LINK_CONN;
                                        end
                                        else if (found_reg)
                                        begin
                                            found_next = 1'b0;
                                            out_load   = 1'b1;
                                            o_cmd      = amls_pkg::CMD_OPEN;
                                            if (addr_len_reg != '0)
                                            begin
                                                o_char        = addr_store_reg[0];
                                                o_last        = stream_last == '0;
                                                idx_next      = AIW'(1);
                                                last_idx_next = stream_last;
                                                if (stream_last != '0)
                                                begin
                                                    ex_next = amls_pkg::EX_STREAM;
                                                end
                                            end
                                        end
                                        else
                                        begin
                                            out_load = 1'b1;
                                            o_cmd    = amls_pkg::CMD_DNS;
                                        end
                                    end
                                end
                                amls_pkg::LINK_CONN:
                                begin
                                    if (ok_reg)
                                    begin
                                        ok_next   = 1'b0;
                                        pend_next = 1'b0;
                                        link_next = amls_pkg::LINK_DISC;
                                    end
                                    else
                                    begin
                                        out_load = 1'b1;
                                        o_cmd    = amls_pkg::CMD_SEND;
                                    end
                                end
                                default:
                                begin
                                    if (ok_reg)
                                    begin
                                        ok_next   = 1'b0;
                                        link_next = amls_pkg::LINK_DISC;
                                    end
                                    else
                                    begin
                                        out_load = 1'b1;
                                        o_cmd    = amls_pkg::CMD_PROBE;
                                    end
                                end
                            endcase
                        end
                        amls_pkg::KIND_SEND:
                        begin
                            pend_next = 1'b1;
                        end
                        default:
                        begin
                            pend_next = pend_reg;
                        end
                    endcase
                end
            end
            amls_pkg::EX_STREAM:
            begin
                if (can_load)
                begin
                    out_load = 1'b1;
                    o_cmd    = amls_pkg::CMD_OPEN;
                    o_char   = addr_store_reg[idx_reg];
                    o_last   = idx_reg == last_idx_reg;
                    idx_next = idx_reg + AIW'(1);
                    if (idx_reg == last_idx_reg)
                    begin
                        ex_next = amls_pkg::EX_RUN;
                    end
                end
            end
            default:
            begin
                ex_next = amls_pkg::EX_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg      <= amls_pkg::LINK_INIT;
            ex_reg        <= amls_pkg::EX_RUN;
            ok_reg        <= 1'b0;
            found_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            line_len_reg  <= '0;
            ovf_reg       <= 1'b0;
            addr_len_reg  <= '0;
            idx_reg       <= '0;
            last_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            link_reg     <= link_next;
            ex_reg       <= ex_next;
            ok_reg       <= ok_next;
            found_reg    <= found_next;
            pend_reg     <= pend_next;
            line_len_reg <= line_len_next;
            ovf_reg      <= ovf_next;
            addr_len_reg <= addr_len_next;
            idx_reg      <= idx_next;
            last_idx_reg <= last_idx_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (keep_we)
        begin
            line_keep_reg[AIW'(line_len_reg)] <= q_rd.entry.data;
        end
        if (addr_copy)
        begin
            addr_store_reg <= line_keep_reg;
        end
        if (out_load)
        begin
            out_cmd_reg  <= o_cmd;
            out_char_reg <= o_char;
            out_last_reg <= o_last;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.command   = out_cmd_reg;
    assign result.addr_char = out_char_reg;
    assign result.last      = out_last_reg;

endmodule

>>> rtl/at_modem_link_sequencer.sv
// Top level of the AT modem link sequencer.
// A tick is queued before the result it causes is registered in the output register.
// Throughput, while results are taken: one item per cycle through the queue and back end
// when no address streams; an open command streams one address character per cycle.
// Reset: rst_n clears link state, flags, lengths, queue and output valid asynchronously.
module at_modem_link_sequencer #(
    parameter int LINE_MAX = amls_pkg::LINE_MAX_DEF,
    parameter int ADDR_MAX = amls_pkg::ADDR_MAX_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    amls_in_if.sink     item,
    amls_out_if.source  result
);

    amls_pkg::q_wr_t  q_wr;
    amls_pkg::q_rd_t  q_rd;
    logic             q_full;
    logic             q_pop;

    amls_front u_front (
        .item (item),
        .full (q_full),
        .wr   (q_wr)
    );

    amls_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_wr),
        .pop   (q_pop),
        .full  (q_full),
        .rd    (q_rd)
    );

    amls_back #(
        .LINE_MAX (LINE_MAX),
        .ADDR_MAX (ADDR_MAX)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_rd   (q_rd),
        .pop    (q_pop),
        .result (result)
    );

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_wr.push |-> !q_full)
        else $error("entry pushed into a full queue");

    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.command != amls_pkg::CMD_OPEN
            |-> result.last && result.addr_char == 8'd0)
        else $error("non-open result is not a single final result");

    a_stream_continues: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.ready && !result.last
            |=> result.valid && result.command == amls_pkg::CMD_OPEN)
        else $error("address stream broken off before its final character");
`endif

endmodule
